[rtl/gnlg_pkg.sv]
package gnlg_pkg;

   localparam int LATENT_CHANNELS_DEF  = 4;
   localparam int DOWNSCALE_FACTOR_DEF = 8;
   localparam int SAMPLE_FRAC_BITS_DEF = 12;

   localparam int TW_N  = 624;
   localparam int TW_M  = 397;
   localparam int TW_AW = 10;

   localparam logic [31:0] TW_MATRIX    = 32'h9908_B0DF;
   localparam logic [31:0] TW_SEED_MULT = 32'd1812433253;
   localparam logic [31:0] TWO_LN2_Q30  = 32'd1488522236;
   localparam logic [31:0] HALF_PI_Q30  = 32'd1686629713;
   localparam logic [30:0] Q30_ONE      = 31'h4000_0000;

   localparam int CNT_W     = 18;
   localparam int TOT_W     = 19;
   localparam int MAX_COUNT = 262144;

   localparam int HORNER_LAST_COS = 4;
   localparam int HORNER_LAST     = 8;

   // floor(n / d) = (n * m) >> k for n < 2^30
   localparam logic [31:0] RECIP_90 = 32'(((64'd1 << 37) + 64'd89) / 64'd90);
   localparam logic [31:0] RECIP_56 = 32'(((64'd1 << 36) + 64'd55) / 64'd56);
   localparam logic [31:0] RECIP_30 = 32'(((64'd1 << 35) + 64'd29) / 64'd30);
   localparam logic [31:0] RECIP_12 = 32'(((64'd1 << 34) + 64'd11) / 64'd12);
   localparam logic [31:0] RECIP_2  = 32'(((64'd1 << 31) + 64'd1) / 64'd2);
   localparam logic [31:0] RECIP_72 = 32'(((64'd1 << 37) + 64'd71) / 64'd72);
   localparam logic [31:0] RECIP_42 = 32'(((64'd1 << 36) + 64'd41) / 64'd42);
   localparam logic [31:0] RECIP_20 = 32'(((64'd1 << 35) + 64'd19) / 64'd20);
   localparam logic [31:0] RECIP_6  = 32'(((64'd1 << 33) + 64'd5) / 64'd6);

   typedef enum logic [1:0] {
      CSR_HEIGHT = 2'd0,
      CSR_WIDTH  = 2'd1,
      CSR_SEED   = 2'd2,
      CSR_SCALE  = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      TW_IDLE,
      TW_SEED_MUL,
      TW_SEED_ADD,
      TW_RD_PAIR,
      TW_RD_FAR,
      TW_GEN
   } tw_state_type;

   typedef enum logic [4:0] {
      GS_IDLE,
      GS_NORM,
      GS_LOG_MUL,
      GS_LOG_UPD,
      GS_LN_A,
      GS_LN_B,
      GS_LN_C,
      GS_SQRT,
      GS_ANG,
      GS_T,
      GS_T2,
      GS_T2_UPD,
      GS_H_MUL1,
      GS_H_MUL2,
      GS_H_UPD,
      GS_SIN,
      GS_SIN_UPD,
      GS_MAG1,
      GS_MAG2,
      GS_RND
   } gs_state_type;

   typedef enum logic [2:0] {
      CT_IDLE,
      CT_SEED,
      CT_WREQ,
      CT_WWAIT,
      CT_MATH,
      CT_MWAIT,
      CT_OUT
   } ct_state_type;

   typedef struct packed {
      logic seed;
      logic next;
   } tw_cmd_type;

   typedef struct packed {
      logic done;
   } tw_stat_type;

   function automatic logic [31:0] horner_mult(input logic [3:0] step);
      logic [31:0] m;
      case (step)
         4'd0:    m = RECIP_90;
         4'd1:    m = RECIP_56;
         4'd2:    m = RECIP_30;
         4'd3:    m = RECIP_12;
         4'd4:    m = RECIP_2;
         4'd5:    m = RECIP_72;
         4'd6:    m = RECIP_42;
         4'd7:    m = RECIP_20;
         4'd8:    m = RECIP_6;
         default: m = RECIP_2;
      endcase
      return m;
   endfunction

   function automatic logic [5:0] horner_shift(input logic [3:0] step);
      logic [5:0] k;
      case (step)
         4'd0:    k = 6'd37;
         4'd1:    k = 6'd36;
         4'd2:    k = 6'd35;
         4'd3:    k = 6'd34;
         4'd4:    k = 6'd31;
         4'd5:    k = 6'd37;
         4'd6:    k = 6'd36;
         4'd7:    k = 6'd35;
         4'd8:    k = 6'd33;
         default: k = 6'd31;
      endcase
      return k;
   endfunction

endpackage

[rtl/gaussian_noise_latent_generator.sv]
// Each accepted transaction draws four twister words, then runs a shared 32x32 multiplier
// sequence: normalize, 30 log squarings, 20 square-root digits and Horner evaluation.
// A restart first reseeds the twister, with one multiply and one add per state word after the first.
// Throughput: one transaction at a time; a finished result may wait while the next is taken.
// Reset is synchronous; the configuration registers return to their defaults and the tensor index to zero.
module gaussian_noise_latent_generator import gnlg_pkg::*; #(
   parameter int LATENT_CHANNELS  = LATENT_CHANNELS_DEF,
   parameter int DOWNSCALE_FACTOR = DOWNSCALE_FACTOR_DEF,
   parameter int SAMPLE_FRAC_BITS = SAMPLE_FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_restart,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [23:0] rsp_sample,
   output logic [17:0]        rsp_element_index,
   output logic               rsp_last,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data
);

   localparam int DS_SHIFT = 12 + $clog2(DOWNSCALE_FACTOR);
   localparam int DS_RECIP = ((1 << DS_SHIFT) + DOWNSCALE_FACTOR - 1) / DOWNSCALE_FACTOR;
   localparam int CH_W     = $clog2(LATENT_CHANNELS + 1);
   localparam int RAW_W    = 24 + CH_W;

   ct_state_type state_ff, state_in;

   logic [11:0] height_ff, width_ff;
   logic [31:0] seed_ff;
   logic [19:0] scale_ff;

   logic [11:0]      rows_ff, cols_ff;
   logic [23:0]      area_ff;
   logic [TOT_W-1:0] total_ff;
   logic [25:0]      rows_prod, cols_prod;
   logic [RAW_W-1:0] raw_total;

   logic [CNT_W-1:0] count_ff;
   logic [1:0]       wsel_ff;
   logic [31:0]      w1_ff, w2_ff, w4_ff;

   logic               rsp_valid_ff;
   logic signed [23:0] rsp_sample_ff;
   logic [CNT_W-1:0]   rsp_index_ff;
   logic               rsp_last_ff;

   tw_cmd_type  tw_cmd;
   tw_stat_type tw_stat;
   logic [31:0] tw_word;
   logic        gs_start, gs_done;
   logic signed [23:0] gs_sample;

   logic             req_accept, rsp_load;
   logic [CNT_W-1:0] idx_now;
   logic             last_now;

   gnlg_twister u_twister (
      .clock (clock),
      .reset (reset),
      .cmd   (tw_cmd),
      .seed  (seed_ff),
      .stat  (tw_stat),
      .word  (tw_word)
   );

   gnlg_gauss #(
      .SAMPLE_FRAC_BITS(SAMPLE_FRAC_BITS)
   ) u_gauss (
      .clock  (clock),
      .reset  (reset),
      .start  (gs_start),
      .w1     (w1_ff),
      .w2     (w2_ff),
      .w4     (w4_ff),
      .scale  (scale_ff),
      .done   (gs_done),
      .sample (gs_sample)
   );

   assign rows_prod = 26'(height_ff) * 26'(DS_RECIP);
   assign cols_prod = 26'(width_ff) * 26'(DS_RECIP);
   assign raw_total = RAW_W'(area_ff) * RAW_W'(LATENT_CHANNELS);

   always_ff @(posedge clock) begin
      rows_ff <= 12'(rows_prod >> DS_SHIFT);
      cols_ff <= 12'(cols_prod >> DS_SHIFT);
      area_ff <= 24'(rows_ff) * 24'(cols_ff);
      if (raw_total > RAW_W'(MAX_COUNT)) begin
         total_ff <= TOT_W'(MAX_COUNT);
      end else if (raw_total == '0) begin
         total_ff <= TOT_W'(1);
      end else begin
         total_ff <= TOT_W'(raw_total);
      end
   end

   assign req_accept = req_valid && !req_stall;
   assign rsp_load   = (state_ff == CT_OUT) && (!rsp_valid_ff || !rsp_stall);
   assign idx_now    = ({1'b0, count_ff} >= total_ff) ? '0 : count_ff;
   assign last_now   = ({1'b0, idx_now} == total_ff - 1'b1);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CT_IDLE: begin
            if (req_accept) begin
               state_in = req_restart ? CT_SEED : CT_WREQ;
            end
         end
         CT_SEED:  if (tw_stat.done) state_in = CT_WREQ;
         CT_WREQ:  state_in = CT_WWAIT;
         CT_WWAIT: begin
            if (tw_stat.done) begin
               state_in = (wsel_ff == 2'd3) ? CT_MATH : CT_WREQ;
            end
         end
         CT_MATH:  state_in = CT_MWAIT;
         CT_MWAIT: if (gs_done) state_in = CT_OUT;
         CT_OUT:   if (rsp_load) state_in = CT_IDLE;
         default:  state_in = CT_IDLE;
      endcase
   end

   always_comb begin
      tw_cmd.seed = (state_ff == CT_IDLE) && req_accept && req_restart;
      tw_cmd.next = (state_ff == CT_WREQ);
      gs_start    = (state_ff == CT_MATH);
      req_stall   = (state_ff != CT_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CT_IDLE;
         height_ff    <= 12'd512;
         width_ff     <= 12'd512;
         seed_ff      <= 32'd5489;
         scale_ff     <= 20'd4096;
         count_ff     <= '0;
         wsel_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write) begin
            case (csr_index)
               CSR_HEIGHT: height_ff <= csr_data[11:0];
               CSR_WIDTH:  width_ff  <= csr_data[11:0];
               CSR_SEED:   seed_ff   <= csr_data;
               CSR_SCALE:  scale_ff  <= csr_data[19:0];
               default:    scale_ff  <= scale_ff;
            endcase
         end
         if (req_accept) begin
            wsel_ff <= '0;
            if (req_restart) begin
               count_ff <= '0;
            end
         end else if (state_ff == CT_WWAIT && tw_stat.done) begin
            wsel_ff <= wsel_ff + 2'd1;
         end
         if (rsp_load) begin
            count_ff     <= last_now ? '0 : idx_now + 1'b1;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == CT_WWAIT && tw_stat.done) begin
         case (wsel_ff)
            2'd0:    w1_ff <= tw_word;
            2'd1:    w2_ff <= tw_word;
            2'd3:    w4_ff <= tw_word;
            default: w4_ff <= w4_ff;
         endcase
      end
      if (rsp_load) begin
         rsp_sample_ff <= gs_sample;
         rsp_index_ff  <= idx_now;
         rsp_last_ff   <= last_now;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sample        = rsp_sample_ff;
   assign rsp_element_index = rsp_index_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

[rtl/gnlg_twister.sv]
module gnlg_twister import gnlg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  tw_cmd_type  cmd,
   input  logic [31:0] seed,
   output tw_stat_type stat,
   output logic [31:0] word
);

   logic [31:0] mt_mem [TW_N];

   tw_state_type     state_ff, state_in;
   logic [TW_AW-1:0] pos_ff, pos_in;
   logic             done_ff, done_in;
   logic [TW_AW-1:0] idx_ff;
   logic [31:0]      prev_ff, prod_ff, cur_ff, nxt_ff, word_ff;
   logic [31:0]      rd_a_ff, rd_b_ff;

   logic             mem_we;
   logic [TW_AW-1:0] mem_waddr, rd_addr_a, rd_addr_b;
   logic [31:0]      mem_wdata;
   logic [TW_AW-1:0] pos_next1, pos_far;
   logic [31:0]      seed_word, mix, regen_v, regen_z;

   function automatic logic [31:0] temper(input logic [31:0] z);
      logic [31:0] y;
      y = z;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & 32'h9D2C_5680);
      y = y ^ ((y << 15) & 32'hEFC6_0000);
      y = y ^ (y >> 18);
      return y;
   endfunction

   assign pos_next1 = (pos_ff == TW_AW'(TW_N - 1)) ? '0 : pos_ff + 1'b1;
   assign pos_far   = (pos_ff >= TW_AW'(TW_N - TW_M)) ? pos_ff - TW_AW'(TW_N - TW_M)
                                                      : pos_ff + TW_AW'(TW_M);
   assign seed_word = prod_ff + {{(32-TW_AW){1'b0}}, idx_ff};
   assign mix       = prev_ff ^ (prev_ff >> 30);
   assign regen_v   = {cur_ff[31], nxt_ff[30:0]};
   assign regen_z   = rd_a_ff ^ (regen_v >> 1) ^ (regen_v[0] ? TW_MATRIX : 32'd0);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         TW_IDLE: begin
            if (cmd.seed) begin
               state_in = TW_SEED_MUL;
            end else if (cmd.next) begin
               state_in = TW_RD_PAIR;
            end
         end
         TW_SEED_MUL: state_in = TW_SEED_ADD;
         TW_SEED_ADD: begin
            if (idx_ff == TW_AW'(TW_N - 1)) begin
               state_in = TW_IDLE;
            end else begin
               state_in = TW_SEED_MUL;
            end
         end
         TW_RD_PAIR: state_in = TW_RD_FAR;
         TW_RD_FAR:  state_in = TW_GEN;
         TW_GEN:     state_in = TW_IDLE;
         default:    state_in = TW_IDLE;
      endcase
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = seed;
      rd_addr_a = pos_ff;
      rd_addr_b = pos_next1;
      done_in   = 1'b0;
      pos_in    = pos_ff;
      case (state_ff)
         TW_IDLE: begin
            if (cmd.seed) begin
               mem_we = 1'b1;
            end
         end
         TW_SEED_ADD: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff;
            mem_wdata = seed_word;
            if (idx_ff == TW_AW'(TW_N - 1)) begin
               done_in = 1'b1;
               pos_in  = '0;
            end
         end
         TW_RD_FAR: begin
            rd_addr_a = pos_far;
         end
         TW_GEN: begin
            mem_we    = 1'b1;
            mem_waddr = pos_ff;
            mem_wdata = regen_z;
            done_in   = 1'b1;
            pos_in    = pos_next1;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mt_mem[mem_waddr] <= mem_wdata;
      end
      rd_a_ff <= mt_mem[rd_addr_a];
      rd_b_ff <= mt_mem[rd_addr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= TW_IDLE;
         pos_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         TW_IDLE: begin
            prev_ff <= seed;
            idx_ff  <= TW_AW'(1);
         end
         TW_SEED_MUL: begin
            prod_ff <= 32'(TW_SEED_MULT * mix);
         end
         TW_SEED_ADD: begin
            prev_ff <= seed_word;
            idx_ff  <= idx_ff + 1'b1;
         end
         TW_RD_FAR: begin
            cur_ff <= rd_a_ff;
            nxt_ff <= rd_b_ff;
         end
         TW_GEN: begin
            word_ff <= temper(regen_z);
         end
         default: begin
            word_ff <= word_ff;
         end
      endcase
   end

   assign stat.done = done_ff;
   assign word      = word_ff;

endmodule

[rtl/gnlg_gauss.sv]
module gnlg_gauss import gnlg_pkg::*; #(
   parameter int SAMPLE_FRAC_BITS = SAMPLE_FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [31:0]        w1,
   input  logic [31:0]        w2,
   input  logic [31:0]        w4,
   input  logic [19:0]        scale,
   output logic               done,
   output logic signed [23:0] sample
);

   localparam int          SH       = 36 - SAMPLE_FRAC_BITS;
   localparam logic [48:0] RND_HALF = 49'(1) << (SH - 1);
   localparam logic [48:0] POS_MAX  = 49'd8388607;
   localparam logic [48:0] NEG_MAX  = 49'd8388608;

   gs_state_type state_ff, state_in;
   logic         done_ff;

   logic [63:0] mul_p_ff;
   logic [31:0] mul_a, mul_b;

   logic [63:0] u_ff;
   logic [6:0]  lead_ff;
   logic [31:0] x_ff;
   logic [29:0] frac_ff;
   logic [4:0]  cnt_ff;
   logic [37:0] acc_ff;
   logic [39:0] v_ff;
   logic [22:0] rem_ff;
   logic [19:0] root_ff;
   logic [29:0] t_ff, t2_ff;
   logic [30:0] h_ff, cos_ff, sin_ff;
   logic [3:0]  step_ff;
   logic [1:0]  quad_ff;
   logic        swap_ff;
   logic signed [23:0] sample_ff;

   logic [63:0] u_start;
   logic [29:0] xw;
   logic [36:0] lval;
   logic [32:0] sq;
   logic [24:0] rem_sh, sq_test;
   logic [37:0] rval;
   logic [61:0] q_full;
   logic [30:0] h_new, c_sel, s_sel, cv;
   logic        neg;
   logic [48:0] rounded;
   logic [23:0] mag_sat;

   assign u_start = ({w2, w1} == 64'd0) ? 64'd1 : {w2, w1};
   assign xw      = w4[29:0];
   assign lval    = {7'(7'd64 - lead_ff), 30'd0} - {7'd0, frac_ff};
   assign sq      = mul_p_ff[63:31];
   assign rem_sh  = {rem_ff, v_ff[39:38]};
   assign sq_test = {3'd0, root_ff, 2'b01};
   assign rval    = acc_ff + {6'd0, mul_p_ff[61:30]};
   assign q_full  = mul_p_ff[61:0] >> horner_shift(step_ff);
   assign h_new   = Q30_ONE - q_full[30:0];
   assign c_sel   = swap_ff ? sin_ff : cos_ff;
   assign s_sel   = swap_ff ? cos_ff : sin_ff;
   assign cv      = quad_ff[0] ? s_sel : c_sel;
   assign neg     = quad_ff[0] ^ quad_ff[1];
   assign rounded = (mul_p_ff[48:0] + RND_HALF) >> SH;

   always_comb begin
      if (neg) begin
         mag_sat = (rounded > NEG_MAX) ? 24'h80_0000 : 24'(24'd0 - rounded[23:0]);
      end else begin
         mag_sat = (rounded > POS_MAX) ? 24'h7F_FFFF : rounded[23:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         GS_IDLE:    if (start) state_in = GS_NORM;
         GS_NORM:    if (u_ff[63]) state_in = GS_LOG_MUL;
         GS_LOG_MUL: state_in = GS_LOG_UPD;
         GS_LOG_UPD: state_in = (cnt_ff == 5'd29) ? GS_LN_A : GS_LOG_MUL;
         GS_LN_A:    state_in = GS_LN_B;
         GS_LN_B:    state_in = GS_LN_C;
         GS_LN_C:    state_in = GS_SQRT;
         GS_SQRT:    if (cnt_ff == 5'd19) state_in = GS_ANG;
         GS_ANG:     state_in = GS_T;
         GS_T:       state_in = GS_T2;
         GS_T2:      state_in = GS_T2_UPD;
         GS_T2_UPD:  state_in = GS_H_MUL1;
         GS_H_MUL1:  state_in = GS_H_MUL2;
         GS_H_MUL2:  state_in = GS_H_UPD;
         GS_H_UPD:   state_in = (step_ff == 4'(HORNER_LAST)) ? GS_SIN : GS_H_MUL1;
         GS_SIN:     state_in = GS_SIN_UPD;
         GS_SIN_UPD: state_in = GS_MAG1;
         GS_MAG1:    state_in = GS_MAG2;
         GS_MAG2:    state_in = GS_RND;
         GS_RND:     state_in = GS_IDLE;
         default:    state_in = GS_IDLE;
      endcase
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         GS_LOG_MUL: begin
            mul_a = x_ff;
            mul_b = x_ff;
         end
         GS_LN_A: begin
            mul_a = {25'd0, lval[36:30]};
            mul_b = TWO_LN2_Q30;
         end
         GS_LN_B: begin
            mul_a = {2'd0, lval[29:0]};
            mul_b = TWO_LN2_Q30;
         end
         GS_ANG: begin
            mul_a = {2'd0, t_ff};
            mul_b = HALF_PI_Q30;
         end
         GS_T2: begin
            mul_a = {2'd0, t_ff};
            mul_b = {2'd0, t_ff};
         end
         GS_H_MUL1: begin
            mul_a = {2'd0, t2_ff};
            mul_b = {1'b0, h_ff};
         end
         GS_H_MUL2: begin
            mul_a = {2'd0, mul_p_ff[59:30]};
            mul_b = horner_mult(step_ff);
         end
         GS_SIN: begin
            mul_a = {2'd0, t_ff};
            mul_b = {1'b0, h_ff};
         end
         GS_MAG1: begin
            mul_a = {12'd0, root_ff};
            mul_b = {1'b0, cv};
         end
         GS_MAG2: begin
            mul_a = {4'd0, mul_p_ff[49:22]};
            mul_b = {12'd0, scale};
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= GS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (state_ff == GS_RND);
      end
   end

   always_ff @(posedge clock) begin
      mul_p_ff <= mul_a * mul_b;
      case (state_ff)
         GS_IDLE: begin
            u_ff    <= u_start;
            lead_ff <= 7'd63;
            quad_ff <= w4[31:30];
            swap_ff <= (xw > 30'h2000_0000);
            t_ff    <= (xw > 30'h2000_0000) ? 30'(31'h4000_0000 - {1'b0, xw}) : xw;
         end
         GS_NORM: begin
            if (u_ff[63]) begin
               x_ff    <= u_ff[63:32];
               frac_ff <= '0;
               cnt_ff  <= '0;
            end else if (u_ff[63:56] == 8'd0) begin
               u_ff    <= u_ff << 8;
               lead_ff <= lead_ff - 7'd8;
            end else begin
               u_ff    <= u_ff << 1;
               lead_ff <= lead_ff - 7'd1;
            end
         end
         GS_LOG_UPD: begin
            if (sq[32]) begin
               x_ff    <= sq[32:1];
               frac_ff <= {frac_ff[28:0], 1'b1};
            end else begin
               x_ff    <= sq[31:0];
               frac_ff <= {frac_ff[28:0], 1'b0};
            end
            cnt_ff <= cnt_ff + 5'd1;
         end
         GS_LN_B: begin
            acc_ff <= mul_p_ff[37:0];
         end
         GS_LN_C: begin
            v_ff    <= {rval[37:0], 2'b00};
            rem_ff  <= '0;
            root_ff <= '0;
            cnt_ff  <= '0;
         end
         GS_SQRT: begin
            if (rem_sh >= sq_test) begin
               rem_ff  <= 23'(rem_sh - sq_test);
               root_ff <= {root_ff[18:0], 1'b1};
            end else begin
               rem_ff  <= rem_sh[22:0];
               root_ff <= {root_ff[18:0], 1'b0};
            end
            v_ff   <= v_ff << 2;
            cnt_ff <= cnt_ff + 5'd1;
         end
         GS_T: begin
            t_ff <= mul_p_ff[59:30];
         end
         GS_T2_UPD: begin
            t2_ff   <= mul_p_ff[59:30];
            h_ff    <= Q30_ONE;
            step_ff <= '0;
         end
         GS_H_UPD: begin
            if (step_ff == 4'(HORNER_LAST_COS)) begin
               cos_ff <= h_new;
               h_ff   <= Q30_ONE;
            end else begin
               h_ff <= h_new;
            end
            step_ff <= step_ff + 4'd1;
         end
         GS_SIN_UPD: begin
            sin_ff <= mul_p_ff[60:30];
         end
         GS_RND: begin
            sample_ff <= signed'(mag_sat);
         end
         default: begin
            sample_ff <= sample_ff;
         end
      endcase
   end

   assign done   = done_ff;
   assign sample = sample_ff;

endmodule

[dv/tb.sv]
module tb;
   import gnlg_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int DRAIN_CYCLES = 300;

   typedef struct {
      logic signed [23:0] sample;
      logic [17:0]        index;
      logic               last;
   } noise_result_t;

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_restart = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [23:0] rsp_sample;
   logic [17:0]        rsp_element_index;
   logic               rsp_last;
   logic               csr_write = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [31:0]        csr_data = '0;

   gaussian_noise_latent_generator DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_restart(req_restart),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_sample(rsp_sample),
      .rsp_element_index(rsp_element_index), .rsp_last(rsp_last),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // model state mirror
   bit [31:0]   mt_words[TW_N];
   int unsigned mt_pos = TW_N;
   int unsigned emitted = 0;
   bit [11:0]   cfg_height = 12'd512;
   bit [11:0]   cfg_width = 12'd512;
   bit [31:0]   cfg_seed = 32'd5489;
   bit [19:0]   cfg_scale = 20'd4096;

   noise_result_t expected_samples[$];
   int          errors = 0;
   longint      cycles = 0;
   bit          quiet = 1'b0;

   function automatic void mt_reseed(bit [31:0] s);
      bit [63:0] p;
      mt_words[0] = s;
      for (int k = 1; k < TW_N; k++) begin
         p = 64'(mt_words[k-1]);
         p = 64'd1812433253 * (p ^ (p >> 30)) + 64'(k);
         mt_words[k] = p[31:0];
      end
      mt_pos = TW_N;
   endfunction

   function automatic bit [31:0] mt_draw();
      bit [31:0] v, z, y;
      if (mt_pos >= TW_N) begin
         for (int k = 0; k < TW_N; k++) begin
            v = (mt_words[k] & 32'h8000_0000) | (mt_words[(k + 1) % TW_N] & 32'h7FFF_FFFF);
            z = mt_words[(k + TW_M) % TW_N] ^ (v >> 1);
            if (v[0]) z ^= TW_MATRIX;
            mt_words[k] = z;
         end
         mt_pos = 0;
      end
      y = mt_words[mt_pos];
      mt_pos++;
      y ^= y >> 11;
      y ^= (y << 7) & 32'h9D2C_5680;
      y ^= (y << 15) & 32'hEFC6_0000;
      y ^= y >> 18;
      return y;
   endfunction

   function automatic bit [63:0] log_radius_sq(bit [63:0] u);
      int        p;
      bit [63:0] x, frac, l, a, b;
      p = 63;
      frac = 0;
      while (u[p] == 1'b0) p--;
      x = (p >= 31) ? (u >> (p - 31)) : (u << (31 - p));
      for (int i = 0; i < 30; i++) begin
         x = (x * x) >> 31;
         frac = frac << 1;
         if (x >= 64'h1_0000_0000) begin
            x = x >> 1;
            frac[0] = 1'b1;
         end
      end
      l = (64'(64 - p) << 30) - frac;
      a = l >> 30;
      b = l & 64'h3FFF_FFFF;
      return a * 64'(TWO_LN2_Q30) + ((b * 64'(TWO_LN2_Q30)) >> 30);
   endfunction

   function automatic bit [63:0] int_sqrt(bit [63:0] v);
      bit [63:0] r, bt;
      r = 0;
      bt = 64'd1 << 62;
      while (bt > v) bt = bt >> 2;
      while (bt != 0) begin
         if (v >= r + bt) begin
            v = v - (r + bt);
            r = (r >> 1) + bt;
         end else begin
            r = r >> 1;
         end
         bt = bt >> 2;
      end
      return r;
   endfunction

   function automatic bit [63:0] sine_q30(bit [63:0] t);
      int        dv[4] = '{72, 42, 20, 6};
      bit [63:0] t2, h;
      t2 = (t * t) >> 30;
      h = 64'd1 << 30;
      for (int i = 0; i < 4; i++) h = (64'd1 << 30) - ((t2 * h) >> 30) / 64'(dv[i]);
      return (t * h) >> 30;
   endfunction

   function automatic bit [63:0] cosine_q30(bit [63:0] t);
      int        dv[5] = '{90, 56, 30, 12, 2};
      bit [63:0] t2, h;
      t2 = (t * t) >> 30;
      h = 64'd1 << 30;
      for (int i = 0; i < 5; i++) h = (64'd1 << 30) - ((t2 * h) >> 30) / 64'(dv[i]);
      return h;
   endfunction

   function automatic noise_result_t predict_sample(bit restart);
      noise_result_t res;
      bit [63:0]     total, idx, u1, radius, c, s, cv, mag, t;
      bit [31:0]     w1, w2, w4, x;
      bit [1:0]      q;
      bit            neg, last;
      if (restart) begin
         mt_reseed(cfg_seed);
         emitted = 0;
      end
      total = 64'(LATENT_CHANNELS_DEF) * 64'(cfg_height / DOWNSCALE_FACTOR_DEF) *
              64'(cfg_width / DOWNSCALE_FACTOR_DEF);
      if (total > MAX_COUNT) total = MAX_COUNT;
      if (total == 0) total = 1;
      idx = emitted;
      if (idx >= total) idx = 0;
      last = (idx == total - 1);
      emitted = last ? 0 : int'(idx + 1);
      w1 = mt_draw();
      w2 = mt_draw();
      void'(mt_draw());
      w4 = mt_draw();
      u1 = {w2, w1};
      if (u1 == 0) u1 = 1;
      radius = int_sqrt(log_radius_sq(u1) << 2);
      q = w4[31:30];
      x = w4 & 32'h3FFF_FFFF;
      if (x <= 32'h2000_0000) begin
         t = (64'(x) * 64'(HALF_PI_Q30)) >> 30;
         c = cosine_q30(t);
         s = sine_q30(t);
      end else begin
         t = (64'(32'h4000_0000 - x) * 64'(HALF_PI_Q30)) >> 30;
         c = sine_q30(t);
         s = cosine_q30(t);
      end
      case (q)
         2'd0: begin cv = c; neg = 1'b0; end
         2'd1: begin cv = s; neg = 1'b1; end
         2'd2: begin cv = c; neg = 1'b1; end
         default: begin cv = s; neg = 1'b0; end
      endcase
      mag = (radius * cv) >> 22;
      mag = (mag * 64'(cfg_scale) + (64'd1 << (35 - SAMPLE_FRAC_BITS_DEF)))
            >> (36 - SAMPLE_FRAC_BITS_DEF);
      if (mag == 0) neg = 1'b0;
      if (neg) begin
         if (mag > 64'd8388608) mag = 64'd8388608;
         res.sample = 24'(64'd16777216 - mag);
      end else begin
         if (mag > 64'd8388607) mag = 64'd8388607;
         res.sample = mag[23:0];
      end
      res.index = idx[17:0];
      res.last = last;
      return res;
   endfunction

   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("MISMATCH %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
      errors++;
   endtask

   task automatic send_item(bit restart);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (req_stall);
      expected_samples.push_back(predict_sample(restart));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_put(csr_index_type idx, bit [31:0] d);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= d;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_HEIGHT: cfg_height = d[11:0];
         CSR_WIDTH:  cfg_width = d[11:0];
         CSR_SEED:   cfg_seed = d;
         default:    cfg_scale = d[19:0];
      endcase
   endtask

   task automatic set_size(bit [11:0] h, bit [11:0] w);
      csr_put(CSR_HEIGHT, 32'(h));
      csr_put(CSR_WIDTH, 32'(w));
   endtask

   // tensor wrap, restart mid-tensor, default seed
   task automatic test_tensor_wrap();
      set_size(12'd8, 12'd8);
      send_item(1'b1);
      repeat (8) send_item(1'b0);
      send_item(1'b1);
      send_item(1'b0);
      wait_idle();
   endtask

   // size corner cases: capped count, zero count, shrink mid-tensor
   task automatic test_size_corners();
      set_size(12'hFFF, 12'hFFF);
      repeat (2) send_item(1'b0);
      wait_idle();
      set_size(12'd4, 12'd2048);
      repeat (2) send_item(1'b0);
      wait_idle();
      set_size(12'd16, 12'd16);
      repeat (6) send_item(1'b0);
      wait_idle();
      set_size(12'd8, 12'd8);
      repeat (2) send_item(1'b0);
      wait_idle();
   endtask

   // scale and seed extremes
   task automatic test_scale_seed();
      csr_put(CSR_SCALE, 32'd0);
      csr_put(CSR_SEED, 32'd0);
      send_item(1'b1);
      send_item(1'b0);
      wait_idle();
      csr_put(CSR_SCALE, 32'hF_FFFF);
      csr_put(CSR_SEED, 32'hFFFF_FFFF);
      send_item(1'b1);
      repeat (3) send_item(1'b0);
      wait_idle();
   endtask

   task automatic test_random();
      int        kind;
      bit [11:0] h, w;
      for (int ph = 0; ph < 12; ph++) begin
         quiet = ($urandom_range(0, 3) == 0);
         kind = $urandom_range(0, 9);
         if (kind < 7) begin
            h = 12'($urandom_range(1, 6) * 8 + $urandom_range(0, 7));
            w = 12'($urandom_range(1, 6) * 8 + $urandom_range(0, 7));
         end else if (kind < 9) begin
            h = 12'($urandom_range(0, 4095));
            w = 12'($urandom_range(0, 4095));
         end else begin
            h = 12'($urandom_range(0, 7));
            w = 12'($urandom_range(0, 4095));
         end
         set_size(h, w);
         csr_put(CSR_SEED, $urandom());
         csr_put(CSR_SCALE, 32'($urandom_range(0, 20'hF_FFFF)));
         send_item($urandom_range(0, 1));
         repeat (90) send_item($urandom_range(0, 29) == 0);
         wait_idle();
      end
      quiet = 1'b0;
   endtask

   always @(posedge clock) begin
      noise_result_t e;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("gaussian_noise_latent_generator verification failed");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_samples.size() == 0) begin
            report_mismatch("unexpected transaction index", rsp_element_index, -1);
         end else begin
            e = expected_samples.pop_front();
            if (rsp_sample !== e.sample) report_mismatch("sample", rsp_sample, e.sample);
            if (rsp_element_index !== e.index)
               report_mismatch("element_index", rsp_element_index, e.index);
            if (rsp_last !== e.last) report_mismatch("last", rsp_last, e.last);
         end
      end
   end

   int stall_left = 0;
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if (quiet) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 2) == 0);
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                   : $urandom_range(0, 3);
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_tensor_wrap();
      test_size_corners();
      test_scale_seed();
      test_random();
      req_valid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("gaussian_noise_latent_generator verification clean");
      end else begin
         $display("gaussian_noise_latent_generator verification failed");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/gnlg_pkg.sv
rtl/gnlg_twister.sv
rtl/gnlg_gauss.sv
rtl/gaussian_noise_latent_generator.sv
dv/tb.sv
